// ===== rtl/sprite_list_tile_expander_assert.svh =====
// assertion macros shared by the sprite list tile expander
`ifndef SPRITE_LIST_TILE_EXPANDER_ASSERT_SVH
`define SPRITE_LIST_TILE_EXPANDER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SLTE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slte same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SLTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slte next-cycle check failed");

`endif

// ===== rtl/slte_pkg.sv =====
`default_nettype none

package slte_pkg;

    // entry word and field widths
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned OFFS_W   = 7;
    localparam int unsigned CODE_W   = 17;
    localparam int unsigned SX_W     = 11;
    localparam int unsigned SY_W     = 17;
    localparam int unsigned PAL_W    = 6;
    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned RUN_W    = 4;

    // stream payload widths
    localparam int unsigned S_TDATA_W = 4 * WORD_W;
    localparam int unsigned M_TDATA_W = 64;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 2'd1;

    // register reset values
    localparam logic signed [OFFS_W-1:0] X_OFFSET_RST = -7'sd42;
    localparam logic signed [OFFS_W-1:0] Y_OFFSET_RST = -7'sd16;

    // attribute decode
    localparam logic [7:0]        END_MARKER = 8'hff;
    localparam logic [PRIO_W-1:0] PRIO_SET   = 8'd252;
    localparam logic [PRIO_W-1:0] PRIO_CLEAR = 8'd254;
    localparam logic [SX_W-1:0]   TILE_STEP  = 11'd16;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic marker;
        logic tile_last;
        logic slot_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/sprite_list_tile_expander.sv =====
// channel   | direction | tdata (low bit up)                          | tuser    | tlast
// s_axis    | in        | x word, y word, code word, attr word        | new_list | -
// m_axis    | out       | code, x, y, palette, mirror, priority, pad  | -        | last_tile
// cfg       | in        | i_cfg_index selects x_offset or y_offset, i_cfg_data 7 bits
//
// an entry is taken and then its run of tiles leaves at one tile a cycle while m_axis is
// not stalled; the tile counter sets the run, attr bits 11:8 plus one (1 to 16 tiles)
// an end marker, a finished list or a full list is taken but gives no tiles
// synchronous active-low reset clears the list state and loads the offset defaults
// a stall on m_axis holds the output register and pauses the tile counter
`default_nettype none
`include "sprite_list_tile_expander_assert.svh"

module sprite_list_tile_expander #(
    parameter int unsigned LIST_ENTRIES = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_wen,
    input  wire logic [slte_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [slte_pkg::OFFS_W-1:0]    i_cfg_data,
    // sprite list entries
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_x_word, entry_y_word, entry_code_word, entry_attr_word
    input  wire logic [slte_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // new_list
    input  wire logic                           s_axis_tuser,
    // tile commands
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tile_code, screen_x, screen_y, palette_group, mirrored, priority_mask, zero pad
    output logic [slte_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // last_tile
    output logic                                m_axis_tlast
);
    import slte_pkg::*;

    t_cmd ctl_cmd;
    t_sts dp_sts;
    logic in_xfer;

    // list control state machine
    slte_ctrl #(
        .LIST_ENTRIES (LIST_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_new_list (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (ctl_cmd)
    );

    // tile arithmetic and output register
    slte_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_entry     (s_axis_tdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .i_cmd       (ctl_cmd),
        .o_sts       (dp_sts)
    );

    // input transaction this cycle
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // checks
    `SLTE_ASSERT_NEXT(a_marker_no_run, i_clk, i_rst_n, in_xfer && dp_sts.marker, s_axis_tready)
    `SLTE_ASSERT_SAME(a_emit_slot_free, i_clk, i_rst_n, ctl_cmd.emit, dp_sts.slot_free)
    `SLTE_ASSERT_SAME(a_load_emit_excl, i_clk, i_rst_n, ctl_cmd.load, !ctl_cmd.emit)
    `SLTE_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, ctl_cmd.emit && dp_sts.tile_last, s_axis_tready)

endmodule

`default_nettype wire

// ===== rtl/slte_ctrl.sv =====
`default_nettype none

module slte_ctrl #(
    parameter int unsigned LIST_ENTRIES = 128
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_new_list,
    output logic               o_in_ready,
    input  wire slte_pkg::t_sts i_sts,
    output slte_pkg::t_cmd     o_cmd
);
    import slte_pkg::*;

    localparam int unsigned CNT_W = $clog2(LIST_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LIST_ENTRIES);

    t_state           r_state, n_state;
    logic             r_finished, n_finished;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic             accept;
    logic             eff_fin;
    logic [CNT_W-1:0] eff_cnt;
    logic [CNT_W-1:0] cnt_inc;
    logic             draw;

    // state and list bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_finished <= 1'b0;
            r_seen     <= '0;
        end else begin
            r_state    <= n_state;
            r_finished <= n_finished;
            r_seen     <= n_seen;
        end
    end

    // list state as seen by the entry in this transaction
    assign accept  = i_in_valid && o_in_ready;
    assign eff_fin = i_new_list ? 1'b0 : r_finished;
    assign eff_cnt = i_new_list ? '0 : r_seen;
    assign cnt_inc = eff_cnt + CNT_W'(1);

    // next state, list update and commands
    always_comb begin
        n_state    = r_state;
        n_finished = r_finished;
        n_seen     = r_seen;
        draw       = 1'b0;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    n_finished = eff_fin;
                    n_seen     = eff_cnt;
                    if (!eff_fin) begin
                        if (eff_cnt >= CNT_FULL) begin
                            n_finished = 1'b1;
                        end else if (i_sts.marker) begin
                            n_finished = 1'b1;
                        end else begin
                            draw   = 1'b1;
                            n_seen = cnt_inc;
                            if (cnt_inc >= CNT_FULL) begin
                                n_finished = 1'b1;
                            end
                        end
                    end
                    if (draw) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (i_sts.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.tile_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/slte_dp.sv =====
`default_nettype none

module slte_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_wen,
    input  wire logic [slte_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [slte_pkg::OFFS_W-1:0]        i_cfg_data,
    // entry words
    input  wire logic [slte_pkg::S_TDATA_W-1:0]     i_entry,
    // tile output
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [slte_pkg::M_TDATA_W-1:0]          o_data,
    output logic                                    o_last,
    // control
    input  wire slte_pkg::t_cmd                     i_cmd,
    output slte_pkg::t_sts                          o_sts
);
    import slte_pkg::*;

    logic [WORD_W-1:0] x_word, y_word, code_word, attr_word;

    logic signed [OFFS_W-1:0] r_x_offset;
    logic signed [OFFS_W-1:0] r_y_offset;

    // current entry, advanced once per tile
    logic [CODE_W-1:0] r_code;
    logic [SX_W-1:0]   r_x;
    logic [SY_W-1:0]   r_y;
    logic [PAL_W-1:0]  r_pal;
    logic              r_mir;
    logic [PRIO_W-1:0] r_prio;
    logic [RUN_W-1:0]  r_left;

    // output register
    logic              r_o_valid;
    logic [CODE_W-1:0] r_o_code;
    logic [SX_W-1:0]   r_o_x;
    logic [SY_W-1:0]   r_o_y;
    logic [PAL_W-1:0]  r_o_pal;
    logic              r_o_mir;
    logic [PRIO_W-1:0] r_o_prio;
    logic              r_o_last;

    logic [SX_W-1:0]   x_start;
    logic [SX_W-1:0]   mirror_span;

    assign x_word    = i_entry[WORD_W-1:0];
    assign y_word    = i_entry[2*WORD_W-1:WORD_W];
    assign code_word = i_entry[3*WORD_W-1:2*WORD_W];
    assign attr_word = i_entry[4*WORD_W-1:3*WORD_W];

    // configuration registers, out of range indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset <= X_OFFSET_RST;
            r_y_offset <= Y_OFFSET_RST;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                CFG_X_OFFSET: r_x_offset <= i_cfg_data;
                CFG_Y_OFFSET: r_y_offset <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // first tile x; mirrored runs start at the far end
    assign mirror_span = attr_word[7] ? {3'b000, attr_word[11:8], 4'b0000} : '0;
    assign x_start     = {2'b00, x_word[8:0]} + SX_W'(r_x_offset) + mirror_span;

    // entry registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_code <= {attr_word[15], code_word};
            r_x    <= x_start;
            r_y    <= {1'b0, y_word} + SY_W'(r_y_offset);
            r_pal  <= attr_word[PAL_W-1:0];
            r_mir  <= attr_word[7];
            r_prio <= attr_word[12] ? PRIO_SET : PRIO_CLEAR;
            r_left <= attr_word[11:8];
        end else if (i_cmd.emit) begin
            r_code <= r_code + CODE_W'(1);
            r_x    <= r_mir ? (r_x - TILE_STEP) : (r_x + TILE_STEP);
            r_left <= r_left - RUN_W'(1);
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_code <= r_code;
            r_o_x    <= r_x;
            r_o_y    <= r_y;
            r_o_pal  <= r_pal;
            r_o_mir  <= r_mir;
            r_o_prio <= r_prio;
            r_o_last <= (r_left == '0);
        end
    end

    assign o_valid = r_o_valid;
    assign o_last  = r_o_last;
    assign o_data  = {4'b0000, r_o_prio, r_o_mir, r_o_pal, r_o_y, r_o_x, r_o_code};

    // status back to the controller
    assign o_sts.marker    = (attr_word[15:8] == END_MARKER);
    assign o_sts.tile_last = (r_left == '0);
    assign o_sts.slot_free = !r_o_valid || i_ready;

endmodule

`default_nettype wire
